/* rtl/cffsa_pkg.sv */
// Shared types and constants for the circular first-free slot allocator.
// No dependencies.
`default_nettype none
package cffsa_pkg;
   localparam int unsigned SLOTS_DEFAULT = 1024;
   localparam int unsigned COUNT_W       = 11;
   localparam int unsigned SLOT_W        = 10;
   localparam int unsigned STATUS_W      = 2;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture request
      logic clr_start;  // begin clearing pass
      logic clr_step;   // clear one word
      logic scan_start; // begin scan
      logic scan_step;  // examine one word
      logic apply;      // write result to map, build response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic scan_done;
      logic in_range;
      logic is_release;
   } sts_type;
endpackage
`default_nettype wire

/* rtl/circular_first_free_slot_allocator_core.sv */
// Top level of the circular first-free slot allocator.
// Depends on cffsa_pkg, cffsa_ctrl, cffsa_dp.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/tready     | tuser[0] op, tdata[9:0] slot
//  rsp     | out | rsp_tvalid/tready     | tdata[9:0] granted_slot, tuser[1:0] status
//  csr     | in  | csr_valid/csr_ready   | csr_data slot_count
//
// Free map kept as 32-bit words in a memory; an allocate scans words
// circularly from the preferred word: check, a memory read, word checks
// until a hit or a full circle (each word in use once, the start word seen
// twice on a full circle), done, apply. A request is taken only in idle, so
// an allocate is through before the next request is accepted.
// Release and out-of-range requests go from check straight to apply.
// Reset and each count write run a clearing pass over all WORDS words and
// take no requests.
// Response sits in a register; a full register holds the controller in apply,
// and in idle the next request is taken in the cycle the response is consumed.
`default_nettype none
module circular_first_free_slot_allocator_core #(
   parameter int unsigned SLOTS = cffsa_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [9:0] slot
   input  wire logic        req_tuser,   // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [9:0] granted_slot
   output logic [1:0]       rsp_tuser,   // [1:0] status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [cffsa_pkg::COUNT_W-1:0] csr_data
);
   cffsa_pkg::cmd_type cmd;
   cffsa_pkg::sts_type sts;
   logic rsp_v_ff;
   logic [cffsa_pkg::SLOT_W-1:0]   oslot;
   logic [cffsa_pkg::STATUS_W-1:0] ost;
   logic taken;
   assign taken = rsp_v_ff && rsp_tready;

   cffsa_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .csr_valid, .csr_ready,
      .rsp_taken(taken), .rsp_full(rsp_v_ff), .sts, .cmd
   );

   cffsa_dp #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .csr_we(csr_valid && csr_ready), .csr_data,
      .req_op(req_tuser), .req_slot(req_tdata[9:0]),
      .rsp_slot(oslot), .rsp_status(ost)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (cmd.apply) rsp_v_ff <= 1'b1;
      else if (taken) rsp_v_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'b0, oslot};
   assign rsp_tuser  = ost;
endmodule
`default_nettype wire

/* rtl/cffsa_ctrl.sv */
// Controller state machine for the slot allocator.
// Depends on cffsa_pkg.
`default_nettype none
module cffsa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               rsp_taken,
   input  wire logic               rsp_full,
   input  wire cffsa_pkg::sts_type sts,
   output cffsa_pkg::cmd_type      cmd
);
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CHECK = 6'b000100,
      S_SCAN  = 6'b001000,
      S_APPLY = 6'b010000,
      S_CSTRT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CSTRT;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      case (state_ff)
         S_CSTRT: begin
            cmd.clr_start = 1'b1;
            state_in      = S_CLEAR;
         end
         S_CLEAR: begin
            if (sts.clr_done) state_in = S_IDLE;
            else              cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            csr_ready = !rsp_full || rsp_taken;
            if (csr_valid && csr_ready) begin
               state_in = S_CSTRT;
            end else begin
               req_tready = !rsp_full || rsp_taken;
               if (req_tvalid && req_tready) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.in_range && !sts.is_release) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!rsp_full || rsp_taken) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_CSTRT;
      endcase
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_apply_room: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_full || rsp_taken)) else $error("apply without room");
endmodule
`default_nettype wire

/* rtl/cffsa_dp.sv */
// Datapath: free map in word memory, word-serial circular scan, response reg.
// Depends on cffsa_pkg.
`default_nettype none
module cffsa_dp #(
   parameter int unsigned SLOTS = cffsa_pkg::SLOTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cffsa_pkg::cmd_type             cmd,
   output cffsa_pkg::sts_type                  sts,
   input  wire logic                           csr_we,
   input  wire logic [cffsa_pkg::COUNT_W-1:0]  csr_data,
   input  wire logic                           req_op,
   input  wire logic [cffsa_pkg::SLOT_W-1:0]   req_slot,
   output logic [cffsa_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [cffsa_pkg::STATUS_W-1:0]      rsp_status
);
   localparam int unsigned WW    = 32;
   localparam int unsigned BW    = $clog2(WW);
   localparam int unsigned WORDS = (SLOTS + WW - 1) / WW;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned IW    = AW + BW;
   localparam int unsigned NW    = $clog2(SLOTS + 1);
   localparam int unsigned CW    = $clog2(WORDS + 2);
   localparam int unsigned SW    = cffsa_pkg::SLOT_W;

   // memory word: bit set = free
   logic [WW-1:0] mem [WORDS];
   logic [WW-1:0] rd_ff;

   logic [NW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] eff;
   logic          op_ff;
   logic [IW-1:0] slot_ff;
   logic          inr_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] step_ff, step_in;
   logic          rdv_ff;
   logic [AW-1:0] rda_ff;
   logic [CW-1:0] rds_ff;
   logic          found_ff, found_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic          done_ff, done_in;
   logic [AW-1:0] clr_ff;
   logic          clrd_ff;
   logic [cffsa_pkg::SLOT_W-1:0]   oslot_ff;
   logic [cffsa_pkg::STATUS_W-1:0] ost_ff;

   always_comb begin
      if ({{(32-cffsa_pkg::COUNT_W){1'b0}}, csr_data} > 32'(SLOTS)) cnt_in = NW'(SLOTS);
      else cnt_in = NW'(csr_data);
   end
   assign eff = cnt_ff;

   // lane mask for a word: bits valid below count, and for first pass at/above slot
   logic [WW-1:0] hit_bits;
   logic [BW-1:0] hit_pos;
   logic          hit_any;
   logic [IW-1:0] base_idx;
   always_comb begin
      base_idx = {rda_ff, {BW{1'b0}}};
      hit_bits = rd_ff;
      for (int b = 0; b < WW; b++) begin
         if ((32'(base_idx) + 32'(b)) >= 32'(eff)) hit_bits[b] = 1'b0;
         if (rds_ff == '0 && (32'(base_idx) + 32'(b)) < 32'(slot_ff)) hit_bits[b] = 1'b0;
      end
      hit_any = |hit_bits;
      hit_pos = '0;
      for (int b = WW - 1; b >= 0; b--)
         if (hit_bits[b]) hit_pos = BW'(b);
   end

   logic [AW-1:0] last_word;
   assign last_word = AW'((32'(eff) - 32'd1) >> BW);

   always_comb begin
      addr_in  = addr_ff;
      step_in  = step_ff;
      found_in = found_ff;
      fidx_in  = fidx_ff;
      done_in  = done_ff;
      if (cmd.scan_start) begin
         addr_in  = slot_ff[IW-1:BW];
         step_in  = '0;
         found_in = 1'b0;
         done_in  = 1'b0;
      end else if (cmd.scan_step) begin
         if (addr_ff == last_word) addr_in = '0;
         else                      addr_in = addr_ff + AW'(1);
         step_in = step_ff + CW'(1);
         if (rdv_ff && !found_ff && hit_any) begin
            found_in = 1'b1;
            fidx_in  = {rda_ff, hit_pos};
            done_in  = 1'b1;
         end else if (rdv_ff && 32'(rds_ff) >= 32'(last_word) + 32'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= NW'(SLOTS);
         clrd_ff <= 1'b0;
         rdv_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (csr_we) cnt_ff <= cnt_in;
         if (cmd.clr_start) begin
            clr_ff  <= '0;
            clrd_ff <= 1'b0;
         end else if (cmd.clr_step) begin
            clr_ff  <= clr_ff + AW'(1);
            clrd_ff <= (32'(clr_ff) == WORDS - 1);
         end
         rdv_ff  <= cmd.scan_step && !done_in;
         done_ff <= done_in;
      end
      addr_ff  <= addr_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      fidx_ff  <= fidx_in;
      rda_ff   <= addr_ff;
      rds_ff   <= step_ff;
      rd_ff    <= mem[addr_ff];
      if (cmd.load_req) begin
         op_ff   <= req_op;
         slot_ff <= IW'(req_slot);
         inr_ff  <= 32'(req_slot) < 32'(eff);
      end
   end

   // second scan pass wraps: after first word the lower bound is lifted
   // memory writes: clear, or single-bit update on apply
   logic [IW-1:0] upd_idx;
   logic          upd_val;
   logic          upd_en;
   logic [WW-1:0] clr_word;
   always_comb begin
      upd_idx = (op_ff == cffsa_pkg::OP_RELEASE) ? slot_ff : fidx_ff;
      upd_val = (op_ff == cffsa_pkg::OP_RELEASE);
      upd_en  = cmd.apply && inr_ff &&
                (op_ff == cffsa_pkg::OP_RELEASE || found_ff);
      for (int b = 0; b < WW; b++)
         clr_word[b] = (32'(clr_ff) * WW + 32'(b)) < 32'(eff);
   end

   // read-modify-write: the word holding upd_idx is read every cycle; its
   // address is stable from check (release) or from the cycle after a hit
   logic [WW-1:0] rel_word_ff;
   always_ff @(posedge clock) begin
      rel_word_ff <= mem[upd_idx[IW-1:BW]];
      if (cmd.clr_step) mem[clr_ff] <= clr_word;
      else if (upd_en) begin
         if (upd_val) mem[upd_idx[IW-1:BW]] <= rel_word_ff | (WW'(1) << upd_idx[BW-1:0]);
         else         mem[upd_idx[IW-1:BW]] <= rel_word_ff & ~(WW'(1) << upd_idx[BW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         if (!inr_ff) begin
            oslot_ff <= '0; ost_ff <= cffsa_pkg::ST_RANGE;
         end else if (op_ff == cffsa_pkg::OP_RELEASE) begin
            oslot_ff <= SW'(slot_ff); ost_ff <= cffsa_pkg::ST_RELEASED;
         end else if (found_ff) begin
            oslot_ff <= SW'(fidx_ff); ost_ff <= cffsa_pkg::ST_GRANTED;
         end else begin
            oslot_ff <= '0; ost_ff <= cffsa_pkg::ST_NONE_FREE;
         end
      end
   end

   assign rsp_slot   = oslot_ff;
   assign rsp_status = ost_ff;
   assign sts.clr_done   = clrd_ff;
   assign sts.scan_done  = done_ff;
   assign sts.in_range   = inr_ff;
   assign sts.is_release = op_ff;
endmodule
`default_nettype wire

/* tb/sv/circular_first_free_slot_allocator_core_test.sv */
// Testbench for the circular first-free slot allocator core.
// Depends on cffsa_pkg and circular_first_free_slot_allocator_core.
// Predicts each response from a bit-level free map and checks it in order.
`timescale 1ns / 1ps
`default_nettype none

class slot_alloc_scoreboard;
   bit        free_map [1024];
   int unsigned slot_count;
   logic [11:0] pending_rsp [$];
   int        mismatch_count;

   function new();
      set_count(11'd1024);
      mismatch_count = 0;
   endfunction

   function int unsigned active_slots();
      return (slot_count > 1024) ? 1024 : slot_count;
   endfunction

   function void set_count(logic [10:0] value);
      int unsigned n;
      slot_count = value;
      n = active_slots();
      for (int i = 0; i < 1024; i++) free_map[i] = (i < n);
   endfunction

   // Note an accepted request and queue the predicted response.
   function void note_request(logic op, logic [9:0] slot);
      int unsigned n;
      int          found;
      logic [9:0]  grant;
      logic [1:0]  status;
      n = active_slots();
      found = -1;
      grant = '0;
      if (slot >= n) begin
         status = cffsa_pkg::ST_RANGE;
      end else if (op == cffsa_pkg::OP_RELEASE) begin
         free_map[slot] = 1'b1;
         grant = slot;
         status = cffsa_pkg::ST_RELEASED;
      end else begin
         for (int i = slot; i < n && found < 0; i++) if (free_map[i]) found = i;
         for (int i = 0; i < n && found < 0; i++) if (free_map[i]) found = i;
         if (found < 0) begin
            status = cffsa_pkg::ST_NONE_FREE;
         end else begin
            free_map[found] = 1'b0;
            grant = found[9:0];
            status = cffsa_pkg::ST_GRANTED;
         end
      end
      pending_rsp.push_back({status, grant});
   endfunction

   function void check_response(logic [9:0] slot, logic [1:0] status);
      logic [11:0] want;
      if (pending_rsp.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected response slot %0d status %0d", slot, status);
         return;
      end
      want = pending_rsp.pop_front();
      if (slot !== want[9:0] || status !== want[11:10]) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("response mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                     want[9:0], want[11:10], slot, status);
      end
   endfunction
endclass

module circular_first_free_slot_allocator_core_test;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data = '0;

   slot_alloc_scoreboard alloc_model = new();

   // Consumer side shaping: random stalls, a long hold-off, or none at the end.
   bit          rsp_quiet = 1'b0;
   bit          rsp_holdoff = 1'b0;
   bit          req_quiet = 1'b0;

   always #1 clock = ~clock;

   circular_first_free_slot_allocator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Sample on the edge; both handshakes are observed before any driver update lands.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         alloc_model.note_request(req_tuser, req_tdata[9:0]);
      if (!reset && rsp_tvalid && rsp_tready)
         alloc_model.check_response(rsp_tdata[9:0], rsp_tuser);
   end

   // Response ready: bursts of stall and go, held low during hold-off.
   initial begin
      int run;
      @(posedge clock);
      forever begin
         if (rsp_holdoff) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else if (rsp_quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 12);
            rsp_tready <= 1'($urandom_range(0, 1));
            repeat (run) @(posedge clock);
         end
      end
   end

   task automatic send_request(logic op, logic [9:0] slot);
      if (!req_quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (alloc_model.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_count(logic [10:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      alloc_model.set_count(value);
   endtask

   // Random phase: allocation-heavy runs with releases of a narrow or full span.
   task automatic random_phase(int unsigned items, int unsigned span);
      for (int i = 0; i < items; i++) begin
         logic op;
         logic [9:0] slot;
         op = ($urandom_range(0, 9) < 4);
         if ($urandom_range(0, 15) == 0) slot = 10'($urandom_range(0, 1023));
         else slot = 10'($urandom_range(0, span - 1));
         send_request(op, slot);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset count of 1024, extremes, wrap, release of a free slot.
      send_request(cffsa_pkg::OP_ALLOC, 10'd1023);
      send_request(cffsa_pkg::OP_ALLOC, 10'd1023);     // wraps to slot 0
      send_request(cffsa_pkg::OP_ALLOC, 10'd0);
      send_request(cffsa_pkg::OP_RELEASE, 10'd0);
      send_request(cffsa_pkg::OP_RELEASE, 10'd0);      // already free
      send_request(cffsa_pkg::OP_RELEASE, 10'd682);
      send_request(cffsa_pkg::OP_ALLOC, 10'd341);
      drain_responses();

      // Count of one: full map, out-of-range, no free slot.
      write_count(11'd1);
      send_request(cffsa_pkg::OP_ALLOC, 10'd0);
      send_request(cffsa_pkg::OP_ALLOC, 10'd0);        // none free
      send_request(cffsa_pkg::OP_ALLOC, 10'd1);        // out of range
      send_request(cffsa_pkg::OP_RELEASE, 10'd1023);   // out of range
      send_request(cffsa_pkg::OP_RELEASE, 10'd0);
      send_request(cffsa_pkg::OP_ALLOC, 10'd0);
      drain_responses();

      // Count of zero: everything out of range.
      write_count(11'd0);
      send_request(cffsa_pkg::OP_ALLOC, 10'd0);
      send_request(cffsa_pkg::OP_RELEASE, 10'd0);
      drain_responses();

      // Count above the slot total saturates.
      write_count(11'd2047);
      send_request(cffsa_pkg::OP_ALLOC, 10'd1023);
      send_request(cffsa_pkg::OP_ALLOC, 10'd1023);
      send_request(cffsa_pkg::OP_RELEASE, 10'd1023);
      drain_responses();

      // Small count, with the receiver held off so the block backs up.
      write_count(11'd5);
      rsp_holdoff = 1'b1;
      fork
         random_phase(40, 8);
         begin
            repeat (400) @(posedge clock);
            rsp_holdoff = 1'b0;
         end
      join
      random_phase(300, 8);
      drain_responses();

      write_count(11'd64);
      random_phase(400, 70);
      drain_responses();

      write_count(11'd1024);
      random_phase(300, 1024);
      drain_responses();

      // Final stretch without idling on either side.
      write_count(11'd33);
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      random_phase(300, 40);
      drain_responses();

      if (alloc_model.mismatch_count == 0 && alloc_model.pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
